// ----- rtl/core/tlvse_pkg.sv -----
// Shared types and constants for the TLV type search extractor.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package tlvse_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;

    localparam int DATA_W    = 8;
    localparam int PLEN_W    = 11;
    localparam int TYPE_W    = 16;
    localparam int VLEN_W    = 16;
    localparam int S_TDATA_W = 40;  // 8 + 11 + 16 = 35, padded to bytes
    localparam int M_TDATA_W = 24;  // 8 + 16
    localparam int KIND_W    = 2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TYPE_HI = 3'd1,
        PH_TYPE_LO = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_SKIP    = 3'd5,
        PH_VALUE   = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE     = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_MALFORMED = 2'd3
    } kind_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              is_first;
        logic [PLEN_W-1:0] payload_length;
        logic [TYPE_W-1:0] search_type;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] value_byte;
        logic [VLEN_W-1:0] value_length;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/tlvse_in_stage.sv -----
// Input register stage: holds one accepted payload byte for the parser.
// Depends on tlvse_pkg.
`default_nettype none

module tlvse_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tlvse_pkg::item_t in_item,
    input  wire logic           take,
    output logic                item_valid,
    output tlvse_pkg::item_t    item
);
    import tlvse_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tlvse_step.sv -----
// Record parser: search state registers and the per-byte update logic.
// Depends on tlvse_pkg.
`default_nettype none

module tlvse_step #(
    parameter int MAX_PAYLOAD = tlvse_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           fire,
    input  wire tlvse_pkg::item_t item,
    output logic                emit,
    output tlvse_pkg::result_t  res
);
    import tlvse_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [PLEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [TYPE_W-1:0]   wanted_type_reg, wanted_type_next;
    logic [TYPE_W-1:0]   record_type_reg, record_type_next;
    logic [VLEN_W-1:0]   record_length_reg, record_length_next;
    logic [VLEN_W-1:0]   value_left_reg, value_left_next;

    phase_t              eff_phase;
    logic [PLEN_W-1:0]   n_clamped;
    logic [PLEN_W-1:0]   eff_left;
    logic [PLEN_W-1:0]   left_dec;
    logic [TYPE_W-1:0]   eff_want;
    logic [TYPE_W-1:0]   cur_type;
    logic [VLEN_W-1:0]   cur_len;
    logic [VLEN_W-1:0]   vl_dec;
    logic                zero_len_start;
    logic                short_hdr;
    logic                len_bad;
    logic                type_hit;

    // A first byte reloads the search context before it is parsed.
    always_comb begin
        if ({6'd0, item.payload_length} > 17'(MAX_PAYLOAD)) begin
            n_clamped = PLEN_W'(MAX_PAYLOAD);
        end else begin
            n_clamped = item.payload_length;
        end
    end

    assign eff_phase      = item.is_first ? PH_TYPE_HI : phase_reg;
    assign eff_left       = item.is_first ? n_clamped : bytes_left_reg;
    assign eff_want       = item.is_first ? item.search_type : wanted_type_reg;
    assign zero_len_start = item.is_first && (n_clamped == '0);
    assign left_dec       = (eff_left != '0) ? eff_left - PLEN_W'(1) : eff_left;
    assign vl_dec         = (value_left_reg != '0) ? value_left_reg - VLEN_W'(1)
                                                   : value_left_reg;
    assign short_hdr      = eff_left < PLEN_W'(4);
    assign cur_type       = {record_type_reg[TYPE_W-1:8], item.data_byte};
    assign cur_len        = {record_length_reg[VLEN_W-1:8], item.data_byte};
    assign len_bad        = cur_len > {5'd0, left_dec};
    assign type_hit       = record_type_reg == eff_want;

    // Next-state logic.
    always_comb begin
        phase_next         = eff_phase;
        bytes_left_next    = left_dec;
        wanted_type_next   = eff_want;
        record_type_next   = record_type_reg;
        record_length_next = record_length_reg;
        value_left_next    = value_left_reg;
        if (zero_len_start) begin
            phase_next = PH_DONE;
        end else begin
            case (eff_phase)
                PH_TYPE_HI: begin
                    if (short_hdr) begin
                        phase_next = PH_DONE;
                    end else begin
                        phase_next       = PH_TYPE_LO;
                        record_type_next = {item.data_byte, 8'd0};
                    end
                end
                PH_TYPE_LO: begin
                    phase_next       = PH_LEN_HI;
                    record_type_next = cur_type;
                end
                PH_LEN_HI: begin
                    phase_next         = PH_LEN_LO;
                    record_length_next = {item.data_byte, 8'd0};
                end
                PH_LEN_LO: begin
                    record_length_next = cur_len;
                    value_left_next    = cur_len;
                    if (len_bad) begin
                        phase_next = PH_DONE;
                    end else if (type_hit) begin
                        phase_next = (cur_len == '0) ? PH_DONE : PH_VALUE;
                    end else if (cur_len == '0) begin
                        phase_next = (left_dec == '0) ? PH_DONE : PH_TYPE_HI;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    value_left_next = vl_dec;
                    if (vl_dec == '0) begin
                        phase_next = (left_dec == '0) ? PH_DONE : PH_TYPE_HI;
                    end
                end
                PH_VALUE: begin
                    value_left_next = vl_dec;
                    if (vl_dec == '0) begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                    phase_next = eff_phase;
                end
            endcase
        end
    end

    // Result logic.
    always_comb begin
        emit = 1'b0;
        res  = '{kind: KIND_VALUE, value_byte: '0, value_length: '0, last: 1'b0};
        if (zero_len_start) begin
            emit     = 1'b1;
            res.kind = KIND_NOT_FOUND;
            res.last = 1'b1;
        end else begin
            case (eff_phase)
                PH_TYPE_HI: begin
                    if (short_hdr) begin
                        emit     = 1'b1;
                        res.kind = KIND_MALFORMED;
                        res.last = 1'b1;
                    end
                end
                PH_LEN_LO: begin
                    if (len_bad) begin
                        emit     = 1'b1;
                        res.kind = KIND_MALFORMED;
                        res.last = 1'b1;
                    end else if (type_hit) begin
                        emit             = 1'b1;
                        res.kind         = KIND_FOUND;
                        res.value_length = cur_len;
                        res.last         = cur_len == '0;
                    end else if (cur_len == '0 && left_dec == '0) begin
                        emit     = 1'b1;
                        res.kind = KIND_NOT_FOUND;
                        res.last = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (vl_dec == '0 && left_dec == '0) begin
                        emit     = 1'b1;
                        res.kind = KIND_NOT_FOUND;
                        res.last = 1'b1;
                    end
                end
                PH_VALUE: begin
                    emit           = 1'b1;
                    res.kind       = KIND_VALUE;
                    res.value_byte = item.data_byte;
                    res.last       = vl_dec == '0;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            bytes_left_reg    <= '0;
            wanted_type_reg   <= '0;
            record_type_reg   <= '0;
            record_length_reg <= '0;
            value_left_reg    <= '0;
        end else if (fire) begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            wanted_type_reg   <= wanted_type_next;
            record_type_reg   <= record_type_next;
            record_length_reg <= record_length_next;
            value_left_reg    <= value_left_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tlvse_out_stage.sv -----
// Output register stage: holds one result transaction until the sink takes it.
// Depends on tlvse_pkg.
`default_nettype none

module tlvse_out_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire tlvse_pkg::result_t load_res,
    output logic                space,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tlvse_pkg::result_t  out_res
);
    import tlvse_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = space ? load : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && space) begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tlv_type_search_extractor_core.sv -----
// Top level of the TLV type search extractor: input stage, parser, output stage.
// Depends on tlvse_pkg, tlvse_in_stage, tlvse_step, tlvse_out_stage.
//
//  Channel | Direction | Ports                          | Carries
//  --------+-----------+--------------------------------+------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | payload bytes, search setup
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | found/value/status
//
// One byte per cycle while m_ is not stalled: each accepted byte is held in the input
// register, parsed by the record logic and registered in the output register, whose
// valid flag drives m_tvalid. With m_ flowing, a transaction can be accepted every
// cycle; a stalled m_ side holds the parser and then the input register, which, if
// empty, still takes one more transaction before s_tready drops. Reset (aresetn low,
// synchronous) clears both valid flags and returns the parser to idle; bytes before
// a first-marked byte are dropped without a result.
`default_nettype none

module tlv_type_search_extractor_core #(
    parameter int MAX_PAYLOAD = tlvse_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [7:0] data_byte, [18:8] payload_length, [34:19] search_type, [39:35] zero
    input  wire logic [tlvse_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] is_first
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] value_byte, [23:8] value_length
    output logic [tlvse_pkg::M_TDATA_W-1:0]        m_tdata,
    // [1:0] kind
    output logic [tlvse_pkg::KIND_W-1:0]           m_tuser,
    output logic                                   m_tlast
);
    import tlvse_pkg::*;

    item_t   s_item;
    item_t   cur_item;
    logic    cur_valid;
    logic    fire;
    logic    emit;
    logic    space;
    result_t step_res;
    result_t m_res;

    // Unpack the slave transaction; the pad bits above search_type are ignored.
    assign s_item.data_byte      = s_tdata[7:0];
    assign s_item.payload_length = s_tdata[18:8];
    assign s_item.search_type    = s_tdata[34:19];
    assign s_item.is_first       = s_tuser;

    // Advance the parser only when the held byte has somewhere to put its result.
    assign fire = cur_valid && space;

    tlvse_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .take       (fire),
        .item_valid (cur_valid),
        .item       (cur_item)
    );

    tlvse_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (cur_item),
        .emit    (emit),
        .res     (step_res)
    );

    tlvse_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && emit),
        .load_res  (step_res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res)
    );

    // Pack the master transaction.
    assign m_tdata = {m_res.value_length, m_res.value_byte};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule

`default_nettype wire
